@@ rtl/core/fdnr_pkg.sv @@
// shared types and constants for the start/end byte deframer with name registry
package fdnr_pkg;

	localparam int DEF_MAX_ENTRIES = 16;
	localparam int DEF_NAME_LEN    = 20;

	localparam logic [7:0] START_BYTE = 8'hAA;
	localparam logic [7:0] END_BYTE   = 8'hBB;
	localparam int         CMD_BYTES  = 4;
	localparam int         ADDR_W     = 32;
	localparam int         IDX_OUT_W  = 4;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_SENDER,
		PH_DEST,
		PH_PAYLOAD
	} phase_t;

	typedef enum logic [1:0] {
		ST_RX,
		ST_SCAN,
		ST_DONE
	} seq_state_t;

endpackage

@@ rtl/core/fdnr_ram.sv @@
// generic single write port ram with registered read
module fdnr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/fdnr_match.sv @@
// shared name compare unit: exact match of length and the bytes below that length
module fdnr_match #(
	parameter int NAME_LEN = 20,
	parameter int LEN_W    = 5
) (
	input  logic [NAME_LEN*8-1:0] buf_name,
	input  logic [LEN_W-1:0]      buf_len,
	input  logic [NAME_LEN*8-1:0] ent_name,
	input  logic [LEN_W-1:0]      ent_len,
	output logic                  hit
);

	always_comb begin
		hit = (ent_len == buf_len);
		for (int i = 0; i < NAME_LEN; i++) begin
			// bytes at or past the length are stale and ignored
			if ((LEN_W'(i) < buf_len) && (ent_name[8*i +: 8] != buf_name[8*i +: 8])) begin
				hit = 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/frame_deframer_name_registry_core.sv @@
// top level: byte parser, lookup sequencer, name table and result register
// results: a command result shows the cycle after its end byte; a name result once the
//   one-entry-per-cycle table scan is done and the result register is free
// throughput: one byte per cycle while parsing and the result register is free; after a
//   name frame's end byte the input stalls until that scan's result is loaded
// reset: arst_n clears parser, entry count and result valid; the table and payload
//   buffer hold no reset and are only read where written
module frame_deframer_name_registry_core #(
	parameter int MAX_ENTRIES = fdnr_pkg::DEF_MAX_ENTRIES,
	parameter int NAME_LEN    = fdnr_pkg::DEF_NAME_LEN
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  rx_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [fdnr_pkg::ADDR_W-1:0] sender_addr,
	output logic [fdnr_pkg::ADDR_W-1:0] dest_addr,
	output logic                        is_command,
	output logic [31:0]                 command_word,
	output logic                        name_found,
	output logic                        new_entry,
	output logic                        table_full,
	output logic [fdnr_pkg::IDX_OUT_W-1:0] entry_index,
	output logic [fdnr_pkg::ADDR_W-1:0] entry_id,
	output logic                        name_truncated
);

	import fdnr_pkg::*;

	// widths derived from the table size and name length
	localparam int LEN_W  = $clog2(NAME_LEN + 1);
	localparam int BI_W   = $clog2(NAME_LEN);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int NAME_W = NAME_LEN * 8;
	localparam int WORD_W = ADDR_W + LEN_W + NAME_W;

	// parser state
	phase_t               phase_q;
	logic [LEN_W-1:0]     cnt_q;
	logic [ADDR_W-1:0]    sender_q;
	logic [ADDR_W-1:0]    dest_q;
	logic                 ovf_q;
	logic [NAME_LEN-1:0][7:0] pbuf_q;

	// sequencer and table bookkeeping
	seq_state_t           state_q, state_d;
	logic [CNT_W-1:0]     entry_cnt_q;
	logic [CNT_W-1:0]     rd_q;
	logic                 cmp_vld_s1;
	logic [IDX_W-1:0]     idx_s1;

	// result held between scan end and output load
	logic                 res_found_q, res_added_q, res_full_q;
	logic [IDX_W-1:0]     res_idx_q;
	logic [ADDR_W-1:0]    res_id_q;

	// output register
	logic                 out_valid_q;

	// handshake and strobes
	logic                 accept_in;
	logic                 end_hit;
	logic                 short_frame;
	logic                 cmd_fire;
	logic                 scan_start;
	logic                 scan_issue, scan_hit, scan_miss, done_fire;
	logic                 out_free;
	logic                 hit;
	logic [31:0]          cmd_word;

	// table port
	logic [WORD_W-1:0]    ram_rdata;
	logic [WORD_W-1:0]    ram_wdata;

	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != ST_RX) || !out_free;
	assign accept_in  = in_valid && !in_stall;

	// end byte only closes a frame once the address beats are in
	assign end_hit     = accept_in && (phase_q == PH_PAYLOAD) && (rx_byte == END_BYTE);
	assign short_frame = (cnt_q <= LEN_W'(CMD_BYTES));
	assign cmd_fire    = end_hit && short_frame;
	assign scan_start  = end_hit && !short_frame;

	// command word from the low payload bytes, unreceived bytes read as zero
	always_comb begin
		cmd_word = '0;
		for (int i = 0; i < CMD_BYTES; i++) begin
			if (LEN_W'(i) < cnt_q) begin
				cmd_word[8*i +: 8] = pbuf_q[i];
			end
		end
	end

	// parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			cnt_q    <= '0;
			sender_q <= '0;
			dest_q   <= '0;
			ovf_q    <= 1'b0;
		end else if (accept_in) begin
			case (phase_q)
				PH_HUNT: begin
					if (rx_byte == START_BYTE) begin
						phase_q  <= PH_SENDER;
						cnt_q    <= '0;
						sender_q <= '0;
						dest_q   <= '0;
						ovf_q    <= 1'b0;
					end
				end
				PH_SENDER: begin
					// little-endian: beat n lands in byte lane n
					sender_q[8*cnt_q[1:0] +: 8] <= rx_byte;
					if (cnt_q[1:0] == 2'd3) begin
						cnt_q   <= '0;
						phase_q <= PH_DEST;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				PH_DEST: begin
					dest_q[8*cnt_q[1:0] +: 8] <= rx_byte;
					if (cnt_q[1:0] == 2'd3) begin
						cnt_q   <= '0;
						phase_q <= PH_PAYLOAD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				PH_PAYLOAD: begin
					if (rx_byte == END_BYTE) begin
						// count kept until the next start byte, the scan still needs it
						phase_q <= PH_HUNT;
					end else if (cnt_q < LEN_W'(NAME_LEN)) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						ovf_q <= 1'b1;
					end
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

	// payload buffer, no reset: bytes past the count are never looked at
	always_ff @(posedge clk) begin
		if (accept_in && (phase_q == PH_PAYLOAD) && (rx_byte != END_BYTE) &&
			(cnt_q < LEN_W'(NAME_LEN))) begin
			pbuf_q[cnt_q[BI_W-1:0]] <= rx_byte;
		end
	end

	// scan sequencer: one table read issued per cycle, compared the cycle after
	always_comb begin
		state_d    = state_q;
		scan_issue = 1'b0;
		scan_hit   = 1'b0;
		scan_miss  = 1'b0;
		done_fire  = 1'b0;
		case (state_q)
			ST_RX: begin
				if (scan_start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cmp_vld_s1 && hit) begin
					scan_hit = 1'b1;
					state_d  = ST_DONE;
				end else if (rd_q < entry_cnt_q) begin
					scan_issue = 1'b1;
				end else if (!cmp_vld_s1) begin
					// every stored entry compared, none matched
					scan_miss = 1'b1;
					state_d   = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					done_fire = 1'b1;
					state_d   = ST_RX;
				end
			end
			default: begin
				state_d = ST_RX;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RX;
		end else begin
			state_q <= state_d;
		end
	end

	// scan bookkeeping and result capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q        <= '0;
			cmp_vld_s1  <= 1'b0;
			idx_s1      <= '0;
			entry_cnt_q <= '0;
			res_found_q <= 1'b0;
			res_added_q <= 1'b0;
			res_full_q  <= 1'b0;
			res_idx_q   <= '0;
			res_id_q    <= '0;
		end else begin
			cmp_vld_s1 <= scan_issue;
			if (scan_start) begin
				rd_q <= '0;
			end else if (scan_issue) begin
				rd_q   <= rd_q + 1'b1;
				idx_s1 <= rd_q[IDX_W-1:0];
			end
			if (scan_hit) begin
				res_found_q <= 1'b1;
				res_added_q <= 1'b0;
				res_full_q  <= 1'b0;
				res_idx_q   <= idx_s1;
				res_id_q    <= ram_rdata[NAME_W+LEN_W +: ADDR_W];
			end else if (scan_miss) begin
				res_found_q <= 1'b0;
				if (entry_cnt_q < CNT_W'(MAX_ENTRIES)) begin
					res_added_q <= 1'b1;
					res_full_q  <= 1'b0;
					res_idx_q   <= entry_cnt_q[IDX_W-1:0];
					res_id_q    <= sender_q;
				end else begin
					res_added_q <= 1'b0;
					res_full_q  <= 1'b1;
					res_idx_q   <= '0;
					res_id_q    <= '0;
				end
			end
			if (done_fire && res_added_q) begin
				entry_cnt_q <= entry_cnt_q + 1'b1;
			end
		end
	end

	// table word: id above length above name bytes
	assign ram_wdata = {sender_q, cnt_q, pbuf_q};

	fdnr_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (done_fire && res_added_q),
		.waddr (entry_cnt_q[IDX_W-1:0]),
		.wdata (ram_wdata),
		.re    (scan_issue),
		.raddr (rd_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	fdnr_match #(
		.NAME_LEN (NAME_LEN),
		.LEN_W    (LEN_W)
	) u_match (
		.buf_name (pbuf_q),
		.buf_len  (cnt_q),
		.ent_name (ram_rdata[NAME_W-1:0]),
		.ent_len  (ram_rdata[NAME_W +: LEN_W]),
		.hit      (hit)
	);

	// result register: loaded by a command frame at once, by a name frame after its scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_fire || done_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire || done_fire) begin
			sender_addr    <= sender_q;
			dest_addr      <= dest_q;
			name_truncated <= ovf_q;
		end
		if (cmd_fire) begin
			is_command   <= 1'b1;
			command_word <= cmd_word;
			name_found   <= 1'b0;
			new_entry    <= 1'b0;
			table_full   <= 1'b0;
			entry_index  <= '0;
			entry_id     <= '0;
		end else if (done_fire) begin
			is_command   <= 1'b0;
			command_word <= '0;
			name_found   <= res_found_q;
			new_entry    <= res_added_q;
			table_full   <= res_full_q;
			entry_index  <= IDX_OUT_W'(res_idx_q);
			entry_id     <= res_id_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/core/fdnr_checker.sv @@
// port-level checks for the deframer core, bound to the top level
module fdnr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] sender_addr,
	input logic [31:0] dest_addr,
	input logic        is_command,
	input logic [31:0] command_word,
	input logic        name_found,
	input logic        new_entry,
	input logic        table_full,
	input logic [3:0]  entry_index,
	input logic [31:0] entry_id,
	input logic        name_truncated
);

	// a stalled result beat stays offered and unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({sender_addr, dest_addr, is_command,
			command_word, name_found, new_entry, table_full, entry_index, entry_id,
			name_truncated}))
		else $error("result beat dropped or changed while stalled");

	// a name frame reports exactly one table outcome
	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_command |-> $onehot({name_found, new_entry, table_full}))
		else $error("name frame without exactly one table outcome");

	// commands carry no table outcome
	a_cmd_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_command |-> !name_found && !new_entry && !table_full)
		else $error("command frame carries a table outcome");

	// names carry no command word
	a_name_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_command |-> command_word == 32'd0)
		else $error("name frame with non-zero command word");

	// no entry reported for commands or a full table
	a_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (is_command || table_full) |-> entry_index == 4'd0 && entry_id == 32'd0)
		else $error("entry reported without a table entry");

endmodule

bind frame_deframer_name_registry_core fdnr_checker u_fdnr_checker (.*);

@@ tb/tb_frame_deframer_name_registry_core.sv @@
// testbench for the start/end byte deframer with name registry: directed frames, then random traffic
`timescale 1ns / 100ps

module tb_frame_deframer_name_registry_core;
	import fdnr_pkg::*;

	localparam int MAX_ENTRIES    = DEF_MAX_ENTRIES;
	localparam int NAME_LEN       = DEF_NAME_LEN;
	localparam int RANDOM_BYTES   = 780;    // frame beats offered in the random part
	localparam int POOL_N         = 24;     // recurring names, more than the table holds
	localparam int LONG_HOLD      = 300;    // receiver hold-off, in cycles
	localparam int DRAIN_CYCLES   = 40;     // idle cycles after the last result, more than a full-table scan takes
	localparam int WATCHDOG_LIMIT = 3000;   // cycles with no beat on either side
	localparam int DIR_N          = 11;

	// everything a result says about a frame apart from its two addresses
	typedef struct packed {
		logic                 is_command;
		logic [31:0]          command_word;
		logic                 name_found;
		logic                 new_entry;
		logic                 table_full;
		logic [IDX_OUT_W-1:0] entry_index;
		logic [ADDR_W-1:0]    entry_id;
		logic                 name_truncated;
	} verdict_t;

	typedef struct packed {
		logic [ADDR_W-1:0] sender_addr;
		logic [ADDR_W-1:0] dest_addr;
		verdict_t          verdict;
	} frame_res_t;

	// one directed frame: payload bytes little-endian in pay, byte 0 first on the wire
	typedef struct packed {
		logic [31:0]  snd;
		logic [31:0]  dst;
		logic [4:0]   plen;
		logic [191:0] pay;
		logic         typed;
		verdict_t     verdict;
	} row_t;

	// typed rows run against a fresh table; the untyped ones go to the predictor
	localparam row_t DIR_ROWS [DIR_N] = '{
		// empty payload, all-zero addresses: command word zero
		'{32'h0000_0000, 32'h0000_0000, 5'd0, 192'h0, 1'b1,
			'{1'b1, 32'h0, 1'b0, 1'b0, 1'b0, 4'd0, 32'h0, 1'b0}},
		// full command, every bit set
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd4, 192'hFFFF_FFFF, 1'b1,
			'{1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 4'd0, 32'h0, 1'b0}},
		// end bytes in the sender, start bytes in dest and payload; short command
		'{32'hBBBB_BBBB, 32'hAAAA_AAAA, 5'd3, 192'hAA_01_02, 1'b1,
			'{1'b1, 32'h00AA_0102, 1'b0, 1'b0, 1'b0, 4'd0, 32'h0, 1'b0}},
		// shortest name, appended at entry 0
		'{32'h1234_5678, 32'h0000_0001, 5'd5, 192'h41_42_43_44_45, 1'b1,
			'{1'b0, 32'h0, 1'b0, 1'b1, 1'b0, 4'd0, 32'h1234_5678, 1'b0}},
		// same name from another sender: found, keeps the stored address
		'{32'h0000_0009, 32'h8000_0000, 5'd5, 192'h41_42_43_44_45, 1'b1,
			'{1'b0, 32'h0, 1'b1, 1'b0, 1'b0, 4'd0, 32'h1234_5678, 1'b0}},
		// entry 0 is a prefix of this one, so no match
		'{32'hCAFE_0001, 32'h0000_0002, 5'd6, 192'h46_41_42_43_44_45, 1'b1,
			'{1'b0, 32'h0, 1'b0, 1'b1, 1'b0, 4'd1, 32'hCAFE_0001, 1'b0}},
		// longest name that fits
		'{32'h0102_0304, 32'h0000_0003, 5'd20, {20{8'hFF}}, 1'b1,
			'{1'b0, 32'h0, 1'b0, 1'b1, 1'b0, 4'd2, 32'h0102_0304, 1'b0}},
		// two bytes too long: dropped, the rest matches entry 2
		'{32'h5555_5555, 32'h0000_0004, 5'd22, {22{8'hFF}}, 1'b1,
			'{1'b0, 32'h0, 1'b1, 1'b0, 1'b0, 4'd2, 32'h0102_0304, 1'b1}},
		'{32'h0000_0007, 32'h0000_0005, 5'd20, 192'h0, 1'b0, '0},
		// start bytes scattered through a name
		'{32'hA5A5_A5A5, 32'h5A5A_5A5A, 5'd9, 192'h00_AA_01_AA_7F_80_AA_00_11, 1'b0, '0},
		// differs from entry 0 in the first byte only
		'{32'h0000_0000, 32'h0000_0000, 5'd5, 192'h41_42_43_44_46, 1'b0, '0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           rx_byte = 8'h00;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [ADDR_W-1:0]    sender_addr;
	logic [ADDR_W-1:0]    dest_addr;
	logic                 is_command;
	logic [31:0]          command_word;
	logic                 name_found;
	logic                 new_entry;
	logic                 table_full;
	logic [IDX_OUT_W-1:0] entry_index;
	logic [ADDR_W-1:0]    entry_id;
	logic                 name_truncated;

	// period 8 ns
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	frame_deframer_name_registry_core #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.NAME_LEN   (NAME_LEN)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sender_addr   (sender_addr),
		.dest_addr     (dest_addr),
		.is_command    (is_command),
		.command_word  (command_word),
		.name_found    (name_found),
		.new_entry     (new_entry),
		.table_full    (table_full),
		.entry_index   (entry_index),
		.entry_id      (entry_id),
		.name_truncated(name_truncated)
	);

	// ---------------------------------------------------------------
	// deframer and registry model, advanced once per accepted input beat
	// ---------------------------------------------------------------
	phase_t      rx_phase;
	int unsigned rx_count;
	logic [31:0] frm_sender;
	logic [31:0] frm_dest;
	logic [7:0]  pay_buf [NAME_LEN];
	logic        trunc_seen;
	logic [7:0]  tbl_name [MAX_ENTRIES][NAME_LEN];
	int unsigned tbl_len [MAX_ENTRIES];
	logic [31:0] tbl_id [MAX_ENTRIES];
	int unsigned tbl_used;

	// results still owed by the block, oldest first
	frame_res_t  frames_due [$];

	// returns 1 when the byte closes a frame, with the frame's result in r
	function automatic bit deframe_byte(input logic [7:0] b, output frame_res_t r);
		int  hit;
		bit  same;
		r = '0;
		case (rx_phase)
			PH_HUNT: begin
				// everything but the start byte is thrown away here
				if (b == START_BYTE) begin
					rx_phase   = PH_SENDER;
					rx_count   = 0;
					frm_sender = '0;
					frm_dest   = '0;
					trunc_seen = 1'b0;
				end
				return 1'b0;
			end
			PH_SENDER: begin
				// no byte is special while addresses are being gathered
				frm_sender[8*rx_count +: 8] = b;
				rx_count++;
				if (rx_count == 4) begin
					rx_count = 0;
					rx_phase = PH_DEST;
				end
				return 1'b0;
			end
			PH_DEST: begin
				frm_dest[8*rx_count +: 8] = b;
				rx_count++;
				if (rx_count == 4) begin
					rx_count = 0;
					rx_phase = PH_PAYLOAD;
				end
				return 1'b0;
			end
			default: begin
				if (b != END_BYTE) begin
					// bytes past the buffer are dropped but remembered
					if (rx_count < NAME_LEN) begin
						pay_buf[rx_count] = b;
						rx_count++;
					end else begin
						trunc_seen = 1'b1;
					end
					return 1'b0;
				end
				r.sender_addr            = frm_sender;
				r.dest_addr              = frm_dest;
				r.verdict.name_truncated = trunc_seen;
				if (rx_count <= CMD_BYTES) begin
					// short payload: command word, missing bytes zero
					r.verdict.is_command = 1'b1;
					for (int k = 0; k < rx_count; k++)
						r.verdict.command_word[8*k +: 8] = pay_buf[k];
				end else begin
					// exact match on length and every byte, lowest index first
					hit = -1;
					for (int e = 0; e < tbl_used && hit < 0; e++) begin
						same = (tbl_len[e] == rx_count);
						for (int k = 0; k < rx_count && same; k++)
							if (tbl_name[e][k] != pay_buf[k])
								same = 1'b0;
						if (same)
							hit = e;
					end
					if (hit >= 0) begin
						r.verdict.name_found  = 1'b1;
						r.verdict.entry_index = hit[IDX_OUT_W-1:0];
						r.verdict.entry_id    = tbl_id[hit];
					end else if (tbl_used < MAX_ENTRIES) begin
						for (int k = 0; k < rx_count; k++)
							tbl_name[tbl_used][k] = pay_buf[k];
						tbl_len[tbl_used]     = rx_count;
						tbl_id[tbl_used]      = frm_sender;
						r.verdict.new_entry   = 1'b1;
						r.verdict.entry_index = tbl_used[IDX_OUT_W-1:0];
						r.verdict.entry_id    = frm_sender;
						tbl_used++;
					end else begin
						r.verdict.table_full = 1'b1;
					end
				end
				rx_phase   = PH_HUNT;
				rx_count   = 0;
				trunc_seen = 1'b0;
				return 1'b1;
			end
		endcase
	endfunction

	// ---------------------------------------------------------------
	// idling: mostly short gaps, now and then a long one
	// ---------------------------------------------------------------
	function automatic int unsigned idle_len();
		if ($urandom_range(0, 99) < 75)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// random payload byte; never the end byte, which would close the frame early
	function automatic logic [7:0] pay_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == END_BYTE)
			b = b ^ 8'h01;
		return b;
	endfunction

	bit          tx_quiet = 1'b0;   // sender runs back to back while set
	int unsigned bytes_offered = 0;
	int unsigned frame_bytes = 0;
	logic [7:0]  pay_q [$];

	// offers one input beat and waits for it to be taken; have_typed swaps the
	// predicted result for one written out by hand
	task automatic offer(input logic [7:0] b, input bit have_typed, input frame_res_t typed);
		int unsigned gap;
		frame_res_t  r;
		gap = (tx_quiet || $urandom_range(0, 1)) ? 0 : idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_offered++;
		if (deframe_byte(b, r))
			frames_due.push_back(have_typed ? typed : r);
	endtask

	// start byte, both addresses little-endian, pay_q, then the end byte unless
	// the frame is meant to be left open
	task automatic send_frame(input logic [31:0] snd, input logic [31:0] dst,
			input bit closed, input bit have_typed, input verdict_t verdict);
		frame_res_t typed;
		typed = {snd, dst, verdict};
		offer(START_BYTE, 1'b0, '0);
		for (int k = 0; k < 4; k++)
			offer(snd[8*k +: 8], 1'b0, '0);
		for (int k = 0; k < 4; k++)
			offer(dst[8*k +: 8], 1'b0, '0);
		foreach (pay_q[k])
			offer(pay_q[k], 1'b0, '0);
		if (closed)
			offer(END_BYTE, have_typed, typed);
		frame_bytes += 9 + pay_q.size() + (closed ? 1 : 0);
	endtask

	// ---------------------------------------------------------------
	// result side: random stall, plus the long hold-off on request
	// ---------------------------------------------------------------
	int unsigned hold_requests = 0;

	initial begin : result_sink
		int unsigned stall_left;
		int unsigned holds_served;
		bit          rx_quiet;
		stall_left   = 0;
		holds_served = 0;
		rx_quiet     = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			// a hold-off fills the result register and backs up into the input
			if (hold_requests != holds_served) begin
				holds_served++;
				stall_left = LONG_HOLD;
			end
			if ($urandom_range(0, 99) == 0)
				rx_quiet = !rx_quiet;
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (!rx_quiet && $urandom_range(0, 2) == 0)
					stall_left = idle_len();
			end
		end
	end

	// ---------------------------------------------------------------
	// result checking
	// ---------------------------------------------------------------
	int unsigned fails = 0;
	int unsigned n_frames = 0, n_cmd = 0, n_found = 0, n_added = 0, n_full = 0, n_trunc = 0;

	function automatic string show(input frame_res_t r);
		return $sformatf("snd=%h dst=%h cmd=%b word=%h found=%b new=%b full=%b idx=%0d id=%h trunc=%b",
			r.sender_addr, r.dest_addr, r.verdict.is_command, r.verdict.command_word,
			r.verdict.name_found, r.verdict.new_entry, r.verdict.table_full,
			r.verdict.entry_index, r.verdict.entry_id, r.verdict.name_truncated);
	endfunction

	task automatic check_frame(input frame_res_t got);
		frame_res_t want;
		string      diff;
		if (frames_due.size() == 0) begin
			fails++;
			if (fails <= 10)
				$display("result beat with nothing outstanding: %s", show(got));
			return;
		end
		want = frames_due.pop_front();
		diff = "";
		if (got.sender_addr !== want.sender_addr)                       diff = {diff, " sender_addr"};
		if (got.dest_addr !== want.dest_addr)                           diff = {diff, " dest_addr"};
		if (got.verdict.is_command !== want.verdict.is_command)         diff = {diff, " is_command"};
		if (got.verdict.command_word !== want.verdict.command_word)     diff = {diff, " command_word"};
		if (got.verdict.name_found !== want.verdict.name_found)         diff = {diff, " name_found"};
		if (got.verdict.new_entry !== want.verdict.new_entry)           diff = {diff, " new_entry"};
		if (got.verdict.table_full !== want.verdict.table_full)         diff = {diff, " table_full"};
		if (got.verdict.entry_index !== want.verdict.entry_index)       diff = {diff, " entry_index"};
		if (got.verdict.entry_id !== want.verdict.entry_id)             diff = {diff, " entry_id"};
		if (got.verdict.name_truncated !== want.verdict.name_truncated) diff = {diff, " name_truncated"};
		if (diff != "") begin
			fails++;
			if (fails <= 10) begin
				$display("result mismatch in%s", diff);
				$display("  expected %s", show(want));
				$display("  actual   %s", show(got));
			end
		end
		n_frames++;
		n_cmd   += want.verdict.is_command;
		n_found += want.verdict.name_found;
		n_added += want.verdict.new_entry;
		n_full  += want.verdict.table_full;
		n_trunc += want.verdict.name_truncated;
	endtask

	always @(posedge clk) begin
		frame_res_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.sender_addr            = sender_addr;
			got.dest_addr              = dest_addr;
			got.verdict.is_command     = is_command;
			got.verdict.command_word   = command_word;
			got.verdict.name_found     = name_found;
			got.verdict.new_entry      = new_entry;
			got.verdict.table_full     = table_full;
			got.verdict.entry_index    = entry_index;
			got.verdict.entry_id       = entry_id;
			got.verdict.name_truncated = name_truncated;
			check_frame(got);
		end
	end

	// watchdog: ends a run in which no beat moves on either side for too long
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		wait (arst_n === 1'b1);
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("frame_deframer_name_registry_core: mismatch");
		$finish;
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	logic [7:0]  pool_name [POOL_N][NAME_LEN];
	int unsigned pool_len [POOL_N];

	initial begin : stimulus
		logic [31:0] snd;
		logic [31:0] dst;
		logic [7:0]  nb;
		int unsigned sel;
		int unsigned p;
		bit          closed;
		bit          hold_done;
		bit          pause_done;

		rx_phase   = PH_HUNT;
		rx_count   = 0;
		frm_sender = '0;
		frm_dest   = '0;
		trunc_seen = 1'b0;
		tbl_used   = 0;
		hold_done  = 1'b0;
		pause_done = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray bytes before any start byte, the end byte among them
		offer(8'h00, 1'b0, '0);
		offer(8'hFF, 1'b0, '0);
		offer(END_BYTE, 1'b0, '0);
		offer(8'h55, 1'b0, '0);

		// directed frames
		for (int i = 0; i < DIR_N; i++) begin
			pay_q.delete();
			for (int k = 0; k < DIR_ROWS[i].plen; k++)
				pay_q.push_back(DIR_ROWS[i].pay[8*k +: 8]);
			send_frame(DIR_ROWS[i].snd, DIR_ROWS[i].dst, 1'b1, DIR_ROWS[i].typed,
				DIR_ROWS[i].verdict);
		end

		// a pool of recurring names; the first four are full length so that their
		// overlong variants match them after truncation
		for (int i = 0; i < POOL_N; i++) begin
			pool_len[i] = (i < 4) ? NAME_LEN : $urandom_range(5, NAME_LEN);
			for (int k = 0; k < NAME_LEN; k++)
				pool_name[i][k] = pay_byte();
		end

		frame_bytes = 0;
		while (frame_bytes < RANDOM_BYTES) begin
			if ($urandom_range(0, 15) == 0)
				tx_quiet = !tx_quiet;

			// long receiver hold-off while frames keep coming
			if (!hold_done && frame_bytes >= 300) begin
				hold_requests <= hold_requests + 1;
				hold_done = 1'b1;
			end
			// sender drains the block completely once
			if (!pause_done && frame_bytes >= 700) begin
				in_valid <= 1'b0;
				while (frames_due.size() != 0)
					@(posedge clk);
				@(posedge clk);
				pause_done = 1'b1;
			end

			// line noise between frames
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					nb = 8'($urandom_range(0, 255));
					if (nb == START_BYTE)
						nb = 8'h00;
					offer(nb, 1'b0, '0);
				end
			end

			pay_q.delete();
			sel = $urandom_range(0, 99);
			if (sel < 25) begin
				repeat ($urandom_range(0, CMD_BYTES)) pay_q.push_back(pay_byte());
			end else if (sel < 60) begin
				p = $urandom_range(0, POOL_N - 1);
				for (int k = 0; k < pool_len[p]; k++)
					pay_q.push_back(pool_name[p][k]);
			end else if (sel < 70) begin
				p = $urandom_range(0, 3);
				for (int k = 0; k < NAME_LEN; k++)
					pay_q.push_back(pool_name[p][k]);
				repeat ($urandom_range(1, 6)) pay_q.push_back(pay_byte());
			end else begin
				repeat ($urandom_range(5, NAME_LEN + 3)) pay_q.push_back(pay_byte());
			end

			snd = $urandom;
			dst = $urandom;
			if ($urandom_range(0, 9) == 0)
				snd[15:8] = END_BYTE;
			if ($urandom_range(0, 9) == 0)
				dst[23:16] = START_BYTE;
			// an unclosed frame swallows the next start byte as payload
			closed = ($urandom_range(0, 19) != 0);
			send_frame(snd, dst, closed, 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d results checked: %0d commands, %0d names found, %0d added, %0d refused, %0d truncated",
			n_frames, n_cmd, n_found, n_added, n_full, n_trunc);
		$display("%0d input beats offered, one long output hold-off and one full drain", bytes_offered);
		if (fails == 0) begin
			$display("frame_deframer_name_registry_core: match");
		end else begin
			$display("%0d result beats wrong", fails);
			$display("frame_deframer_name_registry_core: mismatch");
		end
		$finish;
	end

endmodule
